@@ rtl/via_pkg.sv @@
//------------------------------------------------------------------------------
// via_pkg
// Shared types and constants of the interface adapter.
//------------------------------------------------------------------------------
package via_pkg;

  localparam int unsigned TickBitsDef = 16;

  typedef enum logic [3:0] {
    OP_READ      = 4'd0,
    OP_WRITE     = 4'd1,
    OP_TICK      = 4'd2,
    OP_CA1       = 4'd3,
    OP_CA2       = 4'd4,
    OP_CB1       = 4'd5,
    OP_CB2       = 4'd6,
    OP_PORTA_IN  = 4'd7,
    OP_PORTB_IN  = 4'd8,
    OP_SHIFT_IN  = 4'd9,
    OP_SHIFT_OUT = 4'd10,
    OP_SHIFT_BYTE = 4'd11
  } op_t;

  // register indexes
  localparam logic [3:0] REG_ORB  = 4'd0;
  localparam logic [3:0] REG_ORA  = 4'd1;
  localparam logic [3:0] REG_DDRB = 4'd2;
  localparam logic [3:0] REG_DDRA = 4'd3;
  localparam logic [3:0] REG_T1CL = 4'd4;
  localparam logic [3:0] REG_T1CH = 4'd5;
  localparam logic [3:0] REG_T1LL = 4'd6;
  localparam logic [3:0] REG_T1LH = 4'd7;
  localparam logic [3:0] REG_T2CL = 4'd8;
  localparam logic [3:0] REG_T2CH = 4'd9;
  localparam logic [3:0] REG_SR   = 4'd10;
  localparam logic [3:0] REG_ACR  = 4'd11;
  localparam logic [3:0] REG_PCR  = 4'd12;
  localparam logic [3:0] REG_IFR  = 4'd13;
  localparam logic [3:0] REG_IER  = 4'd14;
  localparam logic [3:0] REG_ORA2 = 4'd15;

  localparam logic [7:0] F_CA2 = 8'h01;
  localparam logic [7:0] F_CA1 = 8'h02;
  localparam logic [7:0] F_SR  = 8'h04;
  localparam logic [7:0] F_CB2 = 8'h08;
  localparam logic [7:0] F_CB1 = 8'h10;
  localparam logic [7:0] F_T2  = 8'h20;
  localparam logic [7:0] F_T1  = 8'h40;

  localparam logic [7:0] BAD_ADDR_DATA = 8'haa;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, apply its event
    logic div_start; // start the timer 1 remainder unit
    logic div_step;  // one remainder step
    logic finish;    // apply timer 1 reload
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
  } status_t;

endpackage

@@ rtl/via_ctrl.sv @@
//------------------------------------------------------------------------------
// via_ctrl
// Controller: sequences one item through event, remainder and result.
//------------------------------------------------------------------------------
module via_ctrl #(
  parameter int unsigned StepBits = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_fire,
  input  via_pkg::status_t    status,
  output via_pkg::cmd_t       cmd,
  output logic                in_ready,
  output logic                out_valid
);

  localparam int unsigned CntW = $clog2(StepBits + 1);

  via_pkg::state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= via_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // advance
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      via_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = via_pkg::ST_FIN;
        end
      end
      via_pkg::ST_FIN: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          cnt_nxt   = CntW'(StepBits);
          state_nxt = via_pkg::ST_DIV;
        end else begin
          state_nxt = via_pkg::ST_OUT;
        end
      end
      via_pkg::ST_DIV: begin
        if (cnt_r != '0) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r - CntW'(1);
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = via_pkg::ST_OUT;
        end
      end
      via_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = via_pkg::ST_IDLE;
      end
      default: state_nxt = via_pkg::ST_IDLE;
    endcase
  end

  ast_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");
  ast_load_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == via_pkg::ST_FIN)
    else $error("load not followed by finish check");
  ast_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> cnt_r == CntW'(StepBits))
    else $error("step count not loaded");

endmodule

@@ rtl/via_datapath.sv @@
//------------------------------------------------------------------------------
// via_datapath
// Register file, timers, control lines, shifter and remainder unit.
//------------------------------------------------------------------------------
module via_datapath #(
  parameter int unsigned TickBits = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  via_pkg::cmd_t     cmd,
  output via_pkg::status_t  status,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_shift,
  input  logic [3:0]        opcode,
  input  logic [11:0]       bus_address,
  input  logic [7:0]        write_data,
  input  logic [15:0]       tick_count,
  output logic [7:0]        read_data,
  output logic [7:0]        port_a_out,
  output logic [7:0]        port_b_out,
  output logic              cb2_out,
  output logic              irq_line,
  output logic              shift_bit_out,
  output logic [7:0]        shift_byte_out,
  output logic              shift_byte_valid
);

  // overrun after timer 1 expiry fits in TickBits
  localparam int unsigned NW = (TickBits > 16) ? TickBits : 16;
  // tick bits actually carried by the input field
  localparam int unsigned TW = (TickBits > 16) ? 16 : TickBits;

  logic [3:0]  ashift_r;
  logic [7:0]  ora_r, orb_r, ina_r, inb_r, ddra_r, ddrb_r, sr_r, acr_r, pcr_r, ifr_r;
  logic [2:0]  scnt_r;
  logic [6:0]  ier_r;
  logic [15:0] t1l_r, t1c_r, t2l_r, t2c_r;
  logic        t1arm_r, t2arm_r, cb2_r;
  logic [3:0]  lines_r;
  logic [7:0]  rd_r, sbyte_r;
  logic        sbit_r, svalid_r;
  logic        need_div_r;
  // remainder unit
  logic [NW-1:0] rem_r, quo_r;

  logic [7:0]  ifr_v, ora_v, orb_v, ina_v, inb_v, ddra_v, ddrb_v, sr_v, acr_v, pcr_v, rd_v;
  logic [7:0]  sbyte_v;
  logic [2:0]  scnt_v;
  logic [6:0]  ier_v;
  logic [15:0] t1l_v, t1c_v, t2l_v, t2c_v;
  logic        t1arm_v, t2arm_v, cb2_v, sbit_v, svalid_v, need_div_v;
  logic [3:0]  lines_v;
  logic [NW-1:0] over_v;
  logic [11:0] sh_addr;
  logic        hi_addr;
  logic [3:0]  ra;
  logic        lvl;
  logic [NW-1:0] ticks;
  logic [NW:0] trial;

  function automatic logic [7:0] flags_fix(input logic [7:0] v, input logic [6:0] en);
    logic [7:0] f;
    f = {1'b0, v[6:0]};
    if ((v[6:0] & en) != 7'd0) f[7] = 1'b1;
    return f;
  endfunction

  function automatic logic cb2_calc(input logic [7:0] acr, input logic [7:0] pcr,
                                    input logic [7:0] sr);
    logic v;
    if ((acr & 8'h1c) != 8'h00) v = acr[4] ? sr[0] : 1'b1;
    else if (!pcr[7]) v = 1'b1;
    else if ((pcr & 8'h60) == 8'h40) v = 1'b0;
    else v = 1'b1;
    return v;
  endfunction

  assign sh_addr = bus_address >> ashift_r;
  assign hi_addr = sh_addr[11:4] != 8'd0;
  assign ra      = sh_addr[3:0];
  assign lvl     = write_data != 8'd0;
  assign ticks   = NW'(tick_count[TW-1:0]);

  // combinational event logic
  always_comb begin
    logic [7:0] f;
    logic       old, en, pol;
    logic [1:0] li;
    f = ifr_r; ora_v = ora_r; orb_v = orb_r; ina_v = ina_r; inb_v = inb_r;
    ddra_v = ddra_r; ddrb_v = ddrb_r; sr_v = sr_r; acr_v = acr_r; pcr_v = pcr_r;
    scnt_v = scnt_r; ier_v = ier_r; t1l_v = t1l_r; t1c_v = t1c_r; t2l_v = t2l_r;
    t2c_v = t2c_r; t1arm_v = t1arm_r; t2arm_v = t2arm_r; cb2_v = cb2_r;
    lines_v = lines_r; rd_v = 8'd0; sbit_v = 1'b0; sbyte_v = 8'd0; svalid_v = 1'b0;
    need_div_v = 1'b0; over_v = '0; old = 1'b0; en = 1'b0; pol = 1'b0; li = 2'd0;
    case (opcode)
      via_pkg::OP_READ: begin
        if (hi_addr) rd_v = via_pkg::BAD_ADDR_DATA;
        else begin
          unique case (ra)
            via_pkg::REG_ORB: begin
              f = f & ~(via_pkg::F_CB1 | via_pkg::F_CB2);
              rd_v = (orb_r & ddrb_r) | (inb_r & ~ddrb_r);
            end
            via_pkg::REG_ORA: begin
              f = f & ~(via_pkg::F_CA1 | via_pkg::F_CA2);
              rd_v = (ora_r & ddra_r) | (ina_r & ~ddra_r);
            end
            via_pkg::REG_DDRB: rd_v = ddrb_r;
            via_pkg::REG_DDRA: rd_v = ddra_r;
            via_pkg::REG_T1CL: begin f = f & ~via_pkg::F_T1; rd_v = t1c_r[7:0]; end
            via_pkg::REG_T1CH: rd_v = t1c_r[15:8];
            via_pkg::REG_T1LL: rd_v = t1l_r[7:0];
            via_pkg::REG_T1LH: rd_v = t1l_r[15:8];
            via_pkg::REG_T2CL: begin f = f & ~via_pkg::F_T2; rd_v = t2c_r[7:0]; end
            via_pkg::REG_T2CH: rd_v = t2c_r[15:8];
            via_pkg::REG_SR: begin f = f & ~via_pkg::F_SR; scnt_v = 3'd0; rd_v = sr_r; end
            via_pkg::REG_ACR: rd_v = acr_r;
            via_pkg::REG_PCR: rd_v = pcr_r;
            via_pkg::REG_IFR: rd_v = ifr_r;
            via_pkg::REG_IER: rd_v = {1'b1, ier_r};
            via_pkg::REG_ORA2: rd_v = (ora_r & ddra_r) | (ina_r & ~ddra_r);
            default: rd_v = 8'd0;
          endcase
          f = flags_fix(f, ier_r);
        end
      end
      via_pkg::OP_WRITE: begin
        if (!hi_addr) begin
          unique case (ra)
            via_pkg::REG_ORB: begin orb_v = write_data; f = f & ~(via_pkg::F_CB1 | via_pkg::F_CB2); end
            via_pkg::REG_ORA, via_pkg::REG_ORA2: begin
              ora_v = write_data; f = f & ~(via_pkg::F_CA1 | via_pkg::F_CA2);
            end
            via_pkg::REG_DDRB: ddrb_v = write_data;
            via_pkg::REG_DDRA: ddra_v = write_data;
            via_pkg::REG_T1CL, via_pkg::REG_T1LL: t1l_v = {t1l_r[15:8], write_data};
            via_pkg::REG_T1CH: begin
              t1l_v = {write_data, t1l_r[7:0]}; t1c_v = t1l_v;
              if (!acr_r[6]) t1arm_v = 1'b1;
              f = f & ~via_pkg::F_T1;
            end
            via_pkg::REG_T1LH: t1l_v = {write_data, t1l_r[7:0]};
            via_pkg::REG_T2CL: t2l_v = {t2l_r[15:8], write_data};
            via_pkg::REG_T2CH: begin
              t2l_v = {write_data, t2l_r[7:0]}; t2c_v = t2l_v;
              if (!acr_r[5]) t2arm_v = 1'b1;
              f = f & ~via_pkg::F_T2;
            end
            via_pkg::REG_SR: begin
              f = f & ~via_pkg::F_SR; sr_v = write_data; scnt_v = 3'd0;
              if ((acr_r & 8'h1c) == 8'h1c) begin
                sbyte_v = write_data; svalid_v = 1'b1; f = f | via_pkg::F_SR;
              end
            end
            via_pkg::REG_ACR: begin
              acr_v = write_data;
              if ((write_data & 8'h1c) == 8'h00) scnt_v = 3'd0;
              cb2_v = cb2_calc(write_data, pcr_r, sr_r);
            end
            via_pkg::REG_PCR: begin pcr_v = write_data; cb2_v = cb2_calc(acr_r, write_data, sr_r); end
            via_pkg::REG_IFR: f = f & ~write_data;
            via_pkg::REG_IER: begin
              if (write_data[7]) ier_v = ier_r | write_data[6:0];
              else ier_v = ier_r & ~write_data[6:0];
            end
            default: f = f;
          endcase
          f = flags_fix(f, ier_v);
        end
      end
      via_pkg::OP_TICK: begin
        // timer 1
        if (ticks < NW'(t1c_r) || t1c_r == 16'd0) begin
          t1c_v = t1c_r - ticks[15:0];
        end else if (acr_r[6]) begin
          f = flags_fix(f | via_pkg::F_T1, ier_r);
          over_v = ticks - NW'(t1c_r);
          if (t1l_r != 16'd0) need_div_v = 1'b1;
          else t1c_v = 16'd0 - over_v[15:0];
        end else begin
          t1c_v = t1c_r - ticks[15:0];
          if (t1arm_r) begin t1arm_v = 1'b0; f = flags_fix(f | via_pkg::F_T1, ier_r); end
        end
        // timer 2
        if (ticks < NW'(t2c_r) || t2c_r == 16'd0) begin
          t2c_v = t2c_r - ticks[15:0];
        end else if (!acr_r[5]) begin
          t2c_v = t2c_r - ticks[15:0];
          if (t2arm_r) begin t2arm_v = 1'b0; f = flags_fix(f | via_pkg::F_T2, ier_r); end
        end
      end
      via_pkg::OP_CA1, via_pkg::OP_CA2, via_pkg::OP_CB1, via_pkg::OP_CB2: begin
        case (opcode)
          via_pkg::OP_CA1: begin li = 2'd0; pol = pcr_r[0]; en = 1'b1; end
          via_pkg::OP_CA2: begin li = 2'd1; pol = pcr_r[2]; en = !pcr_r[3]; end
          via_pkg::OP_CB1: begin li = 2'd2; pol = pcr_r[4]; en = 1'b1; end
          default: begin
            li = 2'd3; pol = pcr_r[6];
            en = ((acr_r & 8'h1c) == 8'h00) && !pcr_r[7];
          end
        endcase
        old = lines_r[li];
        lines_v[li] = lvl;
        if (en && old != lvl && lvl == pol) begin
          case (li)
            2'd0: f = flags_fix(f | via_pkg::F_CA1, ier_r);
            2'd1: f = flags_fix(f | via_pkg::F_CA2, ier_r);
            2'd2: f = flags_fix(f | via_pkg::F_CB1, ier_r);
            default: f = flags_fix(f | via_pkg::F_CB2, ier_r);
          endcase
        end
      end
      via_pkg::OP_PORTA_IN: ina_v = write_data;
      via_pkg::OP_PORTB_IN: inb_v = write_data;
      via_pkg::OP_SHIFT_IN: begin
        if ((acr_r & 8'h1c) == 8'h0c) begin
          sr_v = {sr_r[6:0], lvl};
          scnt_v = scnt_r + 3'd1;
          if (scnt_v == 3'd0) f = f | via_pkg::F_SR;
          f = flags_fix(f | via_pkg::F_CB1, ier_r);
        end
      end
      via_pkg::OP_SHIFT_OUT: begin
        if ((acr_r & 8'h1c) == 8'h1c) begin
          sbit_v = sr_r[7];
          sr_v = {sr_r[6:0], sr_r[7]};
          scnt_v = scnt_r + 3'd1;
          if (scnt_v == 3'd0) f = flags_fix(f | via_pkg::F_SR, ier_r);
        end
      end
      via_pkg::OP_SHIFT_BYTE: begin
        if ((acr_r & 8'h1c) == 8'h0c) begin
          sr_v = write_data; scnt_v = 3'd0;
          f = flags_fix(f | via_pkg::F_SR, ier_r);
        end
      end
      default: f = ifr_r;
    endcase
    ifr_v = f;
  end

  assign trial = {rem_r, quo_r[NW-1]} - (NW+1)'(t1l_r);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) ashift_r <= '0;
    else if (cfg_we) ashift_r <= cfg_shift;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ora_r <= '0; orb_r <= '0; ina_r <= '0; inb_r <= '0; ddra_r <= '0; ddrb_r <= '0;
      sr_r <= '0; acr_r <= '0; pcr_r <= '0; ifr_r <= '0; scnt_r <= '0; ier_r <= '0;
      t1l_r <= '0; t1c_r <= '0; t2l_r <= '0; t2c_r <= '0; t1arm_r <= 1'b0;
      t2arm_r <= 1'b0; cb2_r <= 1'b0; lines_r <= '0; need_div_r <= 1'b0;
    end else if (cmd.load) begin
      ora_r <= ora_v; orb_r <= orb_v; ina_r <= ina_v; inb_r <= inb_v;
      ddra_r <= ddra_v; ddrb_r <= ddrb_v; sr_r <= sr_v; acr_r <= acr_v; pcr_r <= pcr_v;
      ifr_r <= ifr_v; scnt_r <= scnt_v; ier_r <= ier_v; t1l_r <= t1l_v; t1c_r <= t1c_v;
      t2l_r <= t2l_v; t2c_r <= t2c_v; t1arm_r <= t1arm_v; t2arm_r <= t2arm_v;
      cb2_r <= cb2_v; lines_r <= lines_v; need_div_r <= need_div_v;
    end else if (cmd.finish) begin
      // reload from latch less the overrun remainder
      t1c_r <= t1l_r - rem_r[15:0];
      need_div_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r <= rd_v; sbit_r <= sbit_v; sbyte_r <= sbyte_v; svalid_r <= svalid_v;
      quo_r <= over_v;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NW-2:0], 1'b0};
    end
  end

  // restoring remainder, one dividend bit a step
  always_ff @(posedge clk) begin
    if (cmd.div_start) rem_r <= '0;
    else if (cmd.div_step) begin
      if (!trial[NW]) rem_r <= trial[NW-1:0];
      else rem_r <= {rem_r[NW-2:0], quo_r[NW-1]};
    end
  end

  assign status.need_div  = need_div_r;
  assign read_data        = rd_r;
  assign port_a_out       = (ora_r & ddra_r) | (ina_r & ~ddra_r);
  assign port_b_out       = (orb_r & ddrb_r) | (inb_r & ~ddrb_r);
  assign cb2_out          = cb2_r;
  assign irq_line         = ifr_r[7];
  assign shift_bit_out    = sbit_r;
  assign shift_byte_out   = sbyte_r;
  assign shift_byte_valid = svalid_r;

  ast_irq_cons: assert property (@(posedge clk) disable iff (!rst_n)
    ifr_r[7] == ((ifr_r[6:0] & ier_r) != 7'd0))
    else $error("irq summary inconsistent");
  ast_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> t1l_r != 16'd0)
    else $error("remainder started with zero latch");
  ast_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> rem_r < NW'(t1l_r))
    else $error("remainder out of range");

endmodule

@@ rtl/versatile_interface_adapter.sv @@
//------------------------------------------------------------------------------
// versatile_interface_adapter
// 6522-style interface adapter taking one event item and returning one result.
//------------------------------------------------------------------------------
// Usage:
//   in_*  : event items (opcode, bus address, data byte, tick count).
//   out_* : one result item per event: read byte, port pins, CB2, IRQ and
//           shift outputs, held until out_tready.
//   cfg_* : address shift register; write only while idle (not enforced).
// For most events the controller goes from the accepting edge through its
// FIN state to OUT, where out_tvalid rises. A tick item that expires timer 1
// in free-running mode with a nonzero latch first runs a bit-serial remainder
// of the overrun by the latch, max(TICK_BITS, 16) steps in the DIV state,
// before OUT. One item is in flight at a time; the next is accepted the cycle
// after the result is taken. Reset (rst_n low, synchronous) clears the state
// registers and timers; the result and remainder registers are not reset.
// A stalled receiver holds the result and blocks new input.
//------------------------------------------------------------------------------
module versatile_interface_adapter #(
  parameter int unsigned TICK_BITS = via_pkg::TickBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] opcode, [15:4] bus_address, [23:16] write_data, [39:24] tick_count
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [15:8] port_a_out, [23:16] port_b_out, [24] cb2_out,
  // [25] irq_line, [26] shift_bit_out, [34:27] shift_byte_out,
  // [35] shift_byte_valid, zero fill above
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int unsigned StepBits = (TICK_BITS > 16) ? TICK_BITS : 16;

  via_pkg::cmd_t    cmd;
  via_pkg::status_t status;
  logic [7:0] rd, pa, pb, sbyte;
  logic       cb2, irq, sbit, svalid;

  assign cfg_ready = 1'b1;

  via_ctrl #(.StepBits(StepBits)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid & in_tready),
    .out_fire  (out_tvalid & out_tready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  via_datapath #(.TickBits(TICK_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid),
    .cfg_shift        (cfg_data),
    .opcode           (in_tdata[3:0]),
    .bus_address      (in_tdata[15:4]),
    .write_data       (in_tdata[23:16]),
    .tick_count       (in_tdata[39:24]),
    .read_data        (rd),
    .port_a_out       (pa),
    .port_b_out       (pb),
    .cb2_out          (cb2),
    .irq_line         (irq),
    .shift_bit_out    (sbit),
    .shift_byte_out   (sbyte),
    .shift_byte_valid (svalid)
  );

  assign out_tdata = {4'd0, svalid, sbyte, sbit, irq, cb2, pb, pa, rd};

endmodule

@@ tb/versatile_interface_adapter_tb.sv @@
//------------------------------------------------------------------------------
// versatile_interface_adapter_tb
// Drives bus, tick, line, port and shift events into the interface adapter.
// A scoreboard keeps its own model of the adapter state, predicts one result
// item per accepted event and checks each result field by field. Both stream
// sides idle at random, and the address shift is stepped through values 0 to 8.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module versatile_interface_adapter_tb;

  // Scoreboard: adapter state model plus queue of predicted result items
  class via_scoreboard;
    logic [3:0]  shift_amt;
    logic [7:0]  ora, orb, pin_a, pin_b, ddra, ddrb, sreg, acr, pcr, ifr;
    logic [6:0]  ier;
    logic [2:0]  scount;
    logic [15:0] t1_lat, t1_cnt, t2_lat, t2_cnt;
    logic        t1_armed, t2_armed, cb2_lvl;
    logic [3:0]  lines;
    logic [39:0] pending_q[$];
    int          errors;

    function new();
      shift_amt = '0; ora = '0; orb = '0; pin_a = '0; pin_b = '0; ddra = '0; ddrb = '0;
      sreg = '0; acr = '0; pcr = '0; ifr = '0; ier = '0; scount = '0;
      t1_lat = '0; t1_cnt = '0; t2_lat = '0; t2_cnt = '0;
      t1_armed = 1'b0; t2_armed = 1'b0; cb2_lvl = 1'b0; lines = '0; errors = 0;
    endfunction

    function void set_flags(logic [7:0] v);
      v[7] = 1'b0;
      if ((v[6:0] & ier) != 7'd0) v[7] = 1'b1;
      ifr = v;
    endfunction

    function logic [7:0] port_a();
      return (ora & ddra) | (pin_a & ~ddra);
    endfunction

    function logic [7:0] port_b();
      return (orb & ddrb) | (pin_b & ~ddrb);
    endfunction

    function void update_cb2();
      if ((acr & 8'h1c) != 8'h00) cb2_lvl = acr[4] ? sreg[0] : 1'b1;
      else if (!pcr[7]) cb2_lvl = 1'b1;
      else if ((pcr & 8'h60) == 8'h40) cb2_lvl = 1'b0;
      else cb2_lvl = 1'b1;
    endfunction

    // Track one control line and raise its flag on the active edge
    function void line_change(int idx, logic lvl, logic pol, logic [7:0] flag, logic en);
      logic old;
      old = lines[idx];
      lines[idx] = lvl;
      if (en && old != lvl && lvl == pol) set_flags(ifr | flag);
    endfunction

    function void run_timer1(int unsigned n);
      if (n < t1_cnt || t1_cnt == 16'd0) begin
        t1_cnt = t1_cnt - n[15:0];
      end else if (acr[6]) begin
        n = n - t1_cnt;
        set_flags(ifr | via_pkg::F_T1);
        if (t1_lat > 16'd0) n = n % t1_lat;
        else n = n & 32'hffff;
        t1_cnt = t1_lat - n[15:0];
      end else begin
        t1_cnt = t1_cnt - n[15:0];
        if (t1_armed) begin
          t1_armed = 1'b0;
          set_flags(ifr | via_pkg::F_T1);
        end
      end
    endfunction

    function void run_timer2(int unsigned n);
      if (n < t2_cnt || t2_cnt == 16'd0) begin
        t2_cnt = t2_cnt - n[15:0];
      end else if (!acr[5]) begin
        t2_cnt = t2_cnt - n[15:0];
        if (t2_armed) begin
          t2_armed = 1'b0;
          set_flags(ifr | via_pkg::F_T2);
        end
      end
    endfunction

    function logic [7:0] reg_read(logic [11:0] a);
      if (a > 12'd15) return via_pkg::BAD_ADDR_DATA;
      case (a[3:0])
        via_pkg::REG_ORB: begin
          set_flags(ifr & ~(via_pkg::F_CB1 | via_pkg::F_CB2));
          return port_b();
        end
        via_pkg::REG_ORA: begin
          set_flags(ifr & ~(via_pkg::F_CA1 | via_pkg::F_CA2));
          return port_a();
        end
        via_pkg::REG_DDRB: return ddrb;
        via_pkg::REG_DDRA: return ddra;
        via_pkg::REG_T1CL: begin set_flags(ifr & ~via_pkg::F_T1); return t1_cnt[7:0]; end
        via_pkg::REG_T1CH: return t1_cnt[15:8];
        via_pkg::REG_T1LL: return t1_lat[7:0];
        via_pkg::REG_T1LH: return t1_lat[15:8];
        via_pkg::REG_T2CL: begin set_flags(ifr & ~via_pkg::F_T2); return t2_cnt[7:0]; end
        via_pkg::REG_T2CH: return t2_cnt[15:8];
        via_pkg::REG_SR: begin set_flags(ifr & ~via_pkg::F_SR); scount = '0; return sreg; end
        via_pkg::REG_ACR: return acr;
        via_pkg::REG_PCR: return pcr;
        via_pkg::REG_IFR: return ifr;
        via_pkg::REG_IER: return {1'b1, ier};
        default: return port_a();
      endcase
    endfunction

    function void reg_write(logic [11:0] a, logic [7:0] v,
                            output logic [7:0] sbyte, output logic svalid);
      sbyte = '0;
      svalid = 1'b0;
      if (a > 12'd15) return;
      case (a[3:0])
        via_pkg::REG_ORB: begin orb = v; set_flags(ifr & ~(via_pkg::F_CB1 | via_pkg::F_CB2)); end
        via_pkg::REG_ORA, via_pkg::REG_ORA2: begin
          ora = v;
          set_flags(ifr & ~(via_pkg::F_CA1 | via_pkg::F_CA2));
        end
        via_pkg::REG_DDRB: ddrb = v;
        via_pkg::REG_DDRA: ddra = v;
        via_pkg::REG_T1CL, via_pkg::REG_T1LL: t1_lat[7:0] = v;
        via_pkg::REG_T1CH: begin
          t1_lat[15:8] = v;
          t1_cnt = t1_lat;
          if (!acr[6]) t1_armed = 1'b1;
          set_flags(ifr & ~via_pkg::F_T1);
        end
        via_pkg::REG_T1LH: t1_lat[15:8] = v;
        via_pkg::REG_T2CL: t2_lat[7:0] = v;
        via_pkg::REG_T2CH: begin
          t2_lat[15:8] = v;
          t2_cnt = t2_lat;
          if (!acr[5]) t2_armed = 1'b1;
          set_flags(ifr & ~via_pkg::F_T2);
        end
        via_pkg::REG_SR: begin
          set_flags(ifr & ~via_pkg::F_SR);
          sreg = v;
          scount = '0;
          if ((acr & 8'h1c) == 8'h1c) begin
            sbyte = v;
            svalid = 1'b1;
            set_flags(ifr | via_pkg::F_SR);
          end
        end
        via_pkg::REG_ACR: begin
          acr = v;
          if ((acr & 8'h1c) == 8'h00) scount = '0;
          update_cb2();
        end
        via_pkg::REG_PCR: begin pcr = v; update_cb2(); end
        via_pkg::REG_IFR: set_flags(ifr & ~v & 8'h7f);
        via_pkg::REG_IER: begin
          if (v[7]) ier = ier | v[6:0];
          else ier = ier & ~v[6:0];
          set_flags(ifr);
        end
        default: ;
      endcase
    endfunction

    // Apply one accepted event and queue the result it should produce
    function void note_item(logic [39:0] d);
      logic [3:0]  op;
      logic [11:0] a;
      logic [7:0]  wd, rd, sbyte;
      logic        lvl, sbit, svalid;
      op = d[3:0];
      a = d[15:4] >> shift_amt;
      wd = d[23:16];
      lvl = (wd != 8'd0);
      rd = '0; sbit = 1'b0; sbyte = '0; svalid = 1'b0;
      case (op)
        via_pkg::OP_READ:     rd = reg_read(a);
        via_pkg::OP_WRITE:    reg_write(a, wd, sbyte, svalid);
        via_pkg::OP_TICK:     begin run_timer1(d[39:24]); run_timer2(d[39:24]); end
        via_pkg::OP_CA1:      line_change(0, lvl, pcr[0], via_pkg::F_CA1, 1'b1);
        via_pkg::OP_CA2:      line_change(1, lvl, pcr[2], via_pkg::F_CA2, !pcr[3]);
        via_pkg::OP_CB1:      line_change(2, lvl, pcr[4], via_pkg::F_CB1, 1'b1);
        via_pkg::OP_CB2:
          line_change(3, lvl, pcr[6], via_pkg::F_CB2, (acr & 8'h1c) == 8'h00 && !pcr[7]);
        via_pkg::OP_PORTA_IN: pin_a = wd;
        via_pkg::OP_PORTB_IN: pin_b = wd;
        via_pkg::OP_SHIFT_IN: if ((acr & 8'h1c) == 8'h0c) begin
          sreg = {sreg[6:0], lvl};
          scount = scount + 3'd1;
          if (scount == 3'd0) set_flags(ifr | via_pkg::F_SR);
          set_flags(ifr | via_pkg::F_CB1);
        end
        via_pkg::OP_SHIFT_OUT: if ((acr & 8'h1c) == 8'h1c) begin
          sbit = sreg[7];
          sreg = {sreg[6:0], sreg[7]};
          scount = scount + 3'd1;
          if (scount == 3'd0) set_flags(ifr | via_pkg::F_SR);
        end
        via_pkg::OP_SHIFT_BYTE: if ((acr & 8'h1c) == 8'h0c) begin
          sreg = wd;
          scount = '0;
          set_flags(ifr | via_pkg::F_SR);
        end
        default: ;
      endcase
      pending_q.push_back({4'b0, svalid, sbyte, sbit, ifr[7], cb2_lvl,
                           port_b(), port_a(), rd});
    endfunction

    function void cmp_field(string nm, logic [7:0] e, logic [7:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, g);
      end
    endfunction

    function void check_result(logic [39:0] g);
      logic [39:0] e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, g);
        return;
      end
      e = pending_q.pop_front();
      cmp_field("read_data", e[7:0], g[7:0]);
      cmp_field("port_a_out", e[15:8], g[15:8]);
      cmp_field("port_b_out", e[23:16], g[23:16]);
      cmp_field("cb2_out", 8'(e[24]), 8'(g[24]));
      cmp_field("irq_line", 8'(e[25]), 8'(g[25]));
      cmp_field("shift_bit_out", 8'(e[26]), 8'(g[26]));
      cmp_field("shift_byte_out", e[34:27], g[34:27]);
      cmp_field("shift_byte_valid", 8'(e[35]), 8'(g[35]));
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready;
  logic [39:0] in_tdata, out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_data;

  via_scoreboard sb;
  int  items_taken, cfg_taken;
  bit  no_gaps, long_hold;

  versatile_interface_adapter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("versatile_interface_adapter_tb failed");
    $finish;
  end

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready === 1'b1) begin
        sb.note_item(in_tdata);
        items_taken++;
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        sb.shift_amt = cfg_data;
        cfg_taken++;
      end
      if (out_tvalid === 1'b1 && out_tready) sb.check_result(out_tdata);
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 0;
        out_tready <= 0;
        repeat (300) @(negedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(out_tvalid === 1'b1));
    end
  end

  task automatic send_item(logic [3:0] op, logic [11:0] addr, logic [7:0] wd,
                           logic [15:0] ticks);
    int gap;
    int target;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {ticks, wd, addr, op};
    target = items_taken + 1;
    wait (items_taken == target);
  endtask

  task automatic write_shift(logic [3:0] v);
    int target;
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    target = cfg_taken + 1;
    wait (cfg_taken == target);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Hold the input back until every predicted result has been checked
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_access(logic [3:0] op, logic [3:0] r, logic [7:0] v);
    send_item(op, 12'(r) << sb.shift_amt, v, 16'($urandom));
  endtask

  // One random event, weighted toward bus traffic
  task automatic random_item();
    int          pick, sh;
    logic [3:0]  op, r;
    logic [7:0]  v;
    logic [11:0] a;
    logic [15:0] t;
    pick = $urandom_range(0, 99);
    sh = int'(sb.shift_amt);
    r = 4'($urandom);
    v = 8'($urandom);
    t = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    if (pick < 25) op = via_pkg::OP_READ;
    else if (pick < 60) op = via_pkg::OP_WRITE;
    else if (pick < 72) op = via_pkg::OP_TICK;
    else if (pick < 97) op = 4'($urandom_range(via_pkg::OP_CA1, via_pkg::OP_SHIFT_BYTE));
    else op = 4'($urandom_range(12, 15));
    if (op == via_pkg::OP_WRITE) begin
      if (r == via_pkg::REG_ACR && $urandom_range(0, 1) == 1)
        v = (v & ~8'h1c) | (($urandom_range(0, 1) == 1) ? 8'h1c : 8'h0c);
      if ((r == via_pkg::REG_T1CL || r == via_pkg::REG_T1LL || r == via_pkg::REG_T2CL ||
           r == via_pkg::REG_T1CH || r == via_pkg::REG_T2CH || r == via_pkg::REG_T1LH) &&
          $urandom_range(0, 2) != 0)
        v = 8'($urandom_range(0, 20));
    end
    if ($urandom_range(0, 9) == 0) a = 12'($urandom);
    else a = (12'(r) << sh) | (12'($urandom) & ((12'd1 << sh) - 12'd1));
    send_item(op, a, v, t);
  endtask

  initial begin
    logic [3:0] shifts[6];
    sb = new();
    items_taken = 0; cfg_taken = 0; no_gaps = 0; long_hold = 0;
    in_tvalid = 0; in_tdata = '0; cfg_valid = 0; cfg_data = '0;
    shifts = '{4'd0, 4'd8, 4'd1, 4'd4, 4'($urandom_range(0, 8)), 4'd0};
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed opening: ports, timers, shift modes, bad addresses
    write_shift(4'd0);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_DDRA, 8'hff);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_ORA, 8'ha5);
    send_item(via_pkg::OP_PORTA_IN, 12'd0, 8'h5a, 16'd0);
    send_item(via_pkg::OP_PORTB_IN, 12'd0, 8'hff, 16'd0);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_IER, 8'hff);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_T1LL, 8'h05);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_T1CH, 8'h00);
    send_item(via_pkg::OP_TICK, 12'd0, 8'd0, 16'd10);
    reg_access(via_pkg::OP_READ, via_pkg::REG_T1CL, 8'd0);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_ACR, 8'h40);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_T1CH, 8'h00);
    send_item(via_pkg::OP_TICK, 12'd0, 8'd0, 16'hffff);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_T1LL, 8'h00);
    send_item(via_pkg::OP_TICK, 12'd0, 8'd0, 16'd3);
    send_item(via_pkg::OP_TICK, 12'd0, 8'd0, 16'hffff);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_ACR, 8'h1c);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_SR, 8'h81);
    send_item(via_pkg::OP_SHIFT_OUT, 12'd0, 8'd0, 16'd0);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_ACR, 8'h0c);
    send_item(via_pkg::OP_SHIFT_IN, 12'd0, 8'h01, 16'd0);
    send_item(via_pkg::OP_SHIFT_BYTE, 12'd0, 8'hff, 16'd0);
    reg_access(via_pkg::OP_READ, via_pkg::REG_IFR, 8'd0);
    send_item(via_pkg::OP_CA1, 12'd0, 8'h80, 16'd0);
    send_item(via_pkg::OP_READ, 12'hfff, 8'd0, 16'd0);
    send_item(4'd15, 12'hfff, 8'hff, 16'hffff);
    reg_access(via_pkg::OP_WRITE, via_pkg::REG_PCR, 8'hc0);
    drain();

    // Random phases across address shift settings
    for (int p = 0; p < 6; p++) begin
      write_shift(shifts[p]);
      no_gaps = (p == 3);
      if (p == 2) long_hold = 1;
      repeat (92) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("versatile_interface_adapter_tb passed");
    end else begin
      $display("versatile_interface_adapter_tb failed");
    end
    $finish;
  end

endmodule
